// ===== rtl/sfcr_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types of the scaled font cell renderer.
package sfcr_pkg;

   // Glyph geometry of the 5x7 font.
   localparam int GLYPH_ROWS  = 7;
   localparam int GLYPH_COLS  = 5;
   localparam int GLYPH_CELLS = GLYPH_ROWS * GLYPH_COLS;
   localparam int GLYPH_BITS  = GLYPH_CELLS;

   // Default screen size in pixels.
   localparam int DEFAULT_SCREEN_WIDTH  = 240;
   localparam int DEFAULT_SCREEN_HEIGHT = 240;

   // Cursor, cell coordinate, scale and output widths.
   localparam int CURSOR_W = 12;
   localparam int COORD_W  = 13;
   localparam int SCALE_W  = 4;
   localparam int OUT_W    = 8;

   // Index and column counter widths.
   localparam int CELL_W = $clog2(GLYPH_CELLS);
   localparam int COL_W  = $clog2(GLYPH_COLS);

   // Clipped rectangle of one cell.
   typedef struct packed {
      logic [OUT_W-1:0] x_start;
      logic [OUT_W-1:0] y_start;
      logic [OUT_W-1:0] x_end;
      logic [OUT_W-1:0] y_end;
      logic             visible;
   } rect_type;

endpackage

// ===== rtl/sfcr_font_rom.sv =====
`timescale 1ns / 1ps
// Character to 5x7 glyph lookup with lower-case folding.
module sfcr_font_rom import sfcr_pkg::*; (
   input  logic [7:0]            char_code,
   output logic [GLYPH_BITS-1:0] glyph
);

   logic [7:0] folded;

   // Fold lower-case letters onto upper case.
   always_comb begin
      if (char_code >= 8'h61 && char_code <= 8'h7A) begin
         folded = char_code - 8'h20;
      end else begin
         folded = char_code;
      end
   end

   // Rows run top to bottom; within a row the leftmost column is the high bit.
   always_comb begin
      unique case (folded)
         8'h25:   glyph = {5'h19, 5'h1A, 5'h02, 5'h04, 5'h08, 5'h0B, 5'h13};
         8'h2D:   glyph = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
         8'h2E:   glyph = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06};
         8'h30:   glyph = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
         8'h31:   glyph = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
         8'h32:   glyph = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
         8'h33:   glyph = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
         8'h34:   glyph = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
         8'h35:   glyph = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
         8'h36:   glyph = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
         8'h37:   glyph = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
         8'h38:   glyph = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
         8'h39:   glyph = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
         8'h3A:   glyph = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
         8'h41:   glyph = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
         8'h42:   glyph = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
         8'h43:   glyph = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
         8'h44:   glyph = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
         8'h45:   glyph = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
         8'h46:   glyph = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
         8'h47:   glyph = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
         8'h48:   glyph = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
         8'h49:   glyph = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
         8'h4B:   glyph = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
         8'h4C:   glyph = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
         8'h4D:   glyph = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
         8'h4E:   glyph = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
         8'h4F:   glyph = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
         8'h50:   glyph = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
         8'h52:   glyph = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
         8'h53:   glyph = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
         8'h54:   glyph = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
         8'h55:   glyph = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
         8'h56:   glyph = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
         8'h57:   glyph = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
         8'h58:   glyph = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
         8'h59:   glyph = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
         8'h5A:   glyph = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
         // Space, unknown codes, J and Q all render blank.
         default: glyph = '0;
      endcase
   end

endmodule

// ===== rtl/sfcr_clip.sv =====
`timescale 1ns / 1ps
// Screen clipping of one glyph cell rectangle.
module sfcr_clip import sfcr_pkg::*; #(
   parameter int SCREEN_WIDTH  = DEFAULT_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEFAULT_SCREEN_HEIGHT
) (
   input  logic [COORD_W-1:0] x_start,
   input  logic [COORD_W-1:0] y_start,
   input  logic [SCALE_W-1:0] scale,
   output rect_type           rect
);

   localparam logic [COORD_W-1:0] MaxX = COORD_W'(SCREEN_WIDTH);
   localparam logic [COORD_W-1:0] MaxY = COORD_W'(SCREEN_HEIGHT);

   logic [COORD_W-1:0] x_end_raw;
   logic [COORD_W-1:0] y_end_raw;
   logic [COORD_W-1:0] x_end;
   logic [COORD_W-1:0] y_end;
   logic               visible;

   // Far edges, limited to the screen size.
   always_comb begin
      x_end_raw = x_start + COORD_W'(scale);
      y_end_raw = y_start + COORD_W'(scale);
      x_end     = (x_end_raw > MaxX) ? MaxX : x_end_raw;
      y_end     = (y_end_raw > MaxY) ? MaxY : y_end_raw;
      visible   = (x_end > x_start) && (y_end > y_start);
   end

   // An empty cell reports zero coordinates.
   always_comb begin
      rect.visible = visible;
      rect.x_start = visible ? x_start[OUT_W-1:0] : '0;
      rect.y_start = visible ? y_start[OUT_W-1:0] : '0;
      rect.x_end   = visible ? x_end[OUT_W-1:0]   : '0;
      rect.y_end   = visible ? y_end[OUT_W-1:0]   : '0;
   end

endmodule

// ===== rtl/scaled_font_cell_renderer.sv =====
`timescale 1ns / 1ps
// The first cell of a character passes the cell registers and then the result register on its way to the result port.
// Each character yields 35 cell rectangles, one cell rectangle per cycle at the result port while it is not stalled.
// The next character is taken in the same cycle as the last cell of the previous one enters the result register.
// Reset clears the cursor, the string top row, the busy flag and the result valid flag; data registers hold.
// Rate is set by the single cell generator, which walks the 35 glyph cells in order.
module scaled_font_cell_renderer import sfcr_pkg::*; #(
   parameter int SCREEN_WIDTH  = DEFAULT_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = DEFAULT_SCREEN_HEIGHT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_char_code,
   input  logic                req_first_of_string,
   input  logic [CURSOR_W-1:0] req_start_x,
   input  logic [CURSOR_W-1:0] req_start_y,
   input  logic [15:0]         req_fg_color,
   input  logic [15:0]         req_bg_color,
   input  logic [SCALE_W-1:0]  req_pixel_scale,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [OUT_W-1:0]    rsp_rect_x_start,
   output logic [OUT_W-1:0]    rsp_rect_y_start,
   output logic [OUT_W-1:0]    rsp_rect_x_end,
   output logic [OUT_W-1:0]    rsp_rect_y_end,
   output logic [15:0]         rsp_rect_color,
   output logic                rsp_visible,
   output logic                rsp_last_cell
);

   localparam logic [CELL_W-1:0] LastCell  = CELL_W'(GLYPH_CELLS - 1);
   localparam logic [COL_W-1:0]  LastCol   = COL_W'(GLYPH_COLS - 1);
   localparam logic [COORD_W-1:0] CursorMax = COORD_W'((1 << CURSOR_W) - 1);

   // Control state.
   logic                busy_ff, busy_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CURSOR_W-1:0] cursor_x_ff, cursor_x_in;
   logic [CURSOR_W-1:0] line_y_ff, line_y_in;

   // Character being drawn.
   logic [GLYPH_BITS-1:0] glyph_ff, glyph_in;
   logic [CURSOR_W-1:0]   x_base_ff, x_base_in;
   logic [COORD_W-1:0]    x_cell_ff, x_cell_in;
   logic [COORD_W-1:0]    y_cell_ff, y_cell_in;
   logic [SCALE_W-1:0]    scale_ff, scale_in;
   logic [15:0]           fg_ff, fg_in;
   logic [15:0]           bg_ff, bg_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [CELL_W-1:0]     cell_ff, cell_in;

   // Result register.
   rect_type    rect_ff, rect_in;
   logic [15:0] color_ff, color_in;
   logic        last_ff, last_in;

   logic                  advance;
   logic                  emit;
   logic                  done;
   logic                  accept;
   logic [CURSOR_W-1:0]   base_x;
   logic [CURSOR_W-1:0]   base_y;
   logic [6:0]            advance_px;
   logic [COORD_W-1:0]    next_x;
   logic [GLYPH_BITS-1:0] rom_glyph;
   rect_type              cell_rect;

   sfcr_font_rom u_font_rom (
      .char_code (req_char_code),
      .glyph     (rom_glyph)
   );

   sfcr_clip #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_clip (
      .x_start (x_cell_ff),
      .y_start (y_cell_ff),
      .scale   (scale_ff),
      .rect    (cell_rect)
   );

   // Handshake: a cell moves on when the result register is free or being emptied.
   always_comb begin
      advance   = !rsp_valid_ff || !rsp_stall;
      emit      = busy_ff && advance;
      done      = emit && (cell_ff == LastCell);
      req_stall = busy_ff && !done;
      accept    = req_valid && !req_stall;
   end

   // Cursor for the new character and its saturating advance.
   always_comb begin
      base_x     = req_first_of_string ? req_start_x : cursor_x_ff;
      base_y     = req_first_of_string ? req_start_y : line_y_ff;
      advance_px = 7'({req_pixel_scale, 2'b00}) + 7'({req_pixel_scale, 1'b0});
      next_x     = {1'b0, base_x} + COORD_W'(advance_px);
      cursor_x_in = cursor_x_ff;
      line_y_in   = line_y_ff;
      if (accept) begin
         cursor_x_in = (next_x > CursorMax) ? CursorMax[CURSOR_W-1:0]
                                            : next_x[CURSOR_W-1:0];
         line_y_in   = base_y;
      end
   end

   // Cell walk: load on transfer, then step column by column and row by row.
   always_comb begin
      busy_in   = busy_ff;
      glyph_in  = glyph_ff;
      x_base_in = x_base_ff;
      x_cell_in = x_cell_ff;
      y_cell_in = y_cell_ff;
      scale_in  = scale_ff;
      fg_in     = fg_ff;
      bg_in     = bg_ff;
      col_in    = col_ff;
      cell_in   = cell_ff;
      if (accept) begin
         busy_in   = 1'b1;
         glyph_in  = rom_glyph;
         x_base_in = base_x;
         x_cell_in = {1'b0, base_x};
         y_cell_in = {1'b0, base_y};
         scale_in  = req_pixel_scale;
         fg_in     = req_fg_color;
         bg_in     = req_bg_color;
         col_in    = '0;
         cell_in   = '0;
      end else if (emit) begin
         busy_in  = !done;
         glyph_in = {glyph_ff[GLYPH_BITS-2:0], 1'b0};
         cell_in  = cell_ff + CELL_W'(1);
         if (col_ff == LastCol) begin
            col_in    = '0;
            x_cell_in = {1'b0, x_base_ff};
            y_cell_in = y_cell_ff + COORD_W'(scale_ff);
         end else begin
            col_in    = col_ff + COL_W'(1);
            x_cell_in = x_cell_ff + COORD_W'(scale_ff);
         end
      end
   end

   // Result register load.
   always_comb begin
      rsp_valid_in = advance ? emit : rsp_valid_ff;
      rect_in      = rect_ff;
      color_in     = color_ff;
      last_in      = last_ff;
      if (emit) begin
         rect_in  = cell_rect;
         color_in = glyph_ff[GLYPH_BITS-1] ? fg_ff : bg_ff;
         last_in  = (cell_ff == LastCell);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cursor_x_ff  <= '0;
         line_y_ff    <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         cursor_x_ff  <= cursor_x_in;
         line_y_ff    <= line_y_in;
      end
   end

   // Data registers.
   always_ff @(posedge clock) begin
      glyph_ff  <= glyph_in;
      x_base_ff <= x_base_in;
      x_cell_ff <= x_cell_in;
      y_cell_ff <= y_cell_in;
      scale_ff  <= scale_in;
      fg_ff     <= fg_in;
      bg_ff     <= bg_in;
      col_ff    <= col_in;
      cell_ff   <= cell_in;
      rect_ff   <= rect_in;
      color_ff  <= color_in;
      last_ff   <= last_in;
   end

   // Result port.
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rect_x_start = rect_ff.x_start;
   assign rsp_rect_y_start = rect_ff.y_start;
   assign rsp_rect_x_end   = rect_ff.x_end;
   assign rsp_rect_y_end   = rect_ff.y_end;
   assign rsp_visible      = rect_ff.visible;
   assign rsp_rect_color   = color_ff;
   assign rsp_last_cell    = last_ff;

endmodule

// ===== tb/sv/scaled_font_cell_renderer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the scaled font cell renderer: directed rows, then random strings.
module scaled_font_cell_renderer_tb;
   import sfcr_pkg::*;

   localparam int CLOCK_HALF     = 2;
   localparam int RESET_CYCLES   = 6;
   localparam int RANDOM_ITEMS   = 320;
   localparam int PHASES         = 3;
   localparam int HOLD_CYCLES    = 400;
   localparam int QUIET_LIMIT    = 2000;
   localparam int DRAIN_CYCLES   = 10;
   localparam int MAX_REPORTS    = 10;
   localparam int ADVANCE_CELLS  = 6;
   localparam int CASE_FOLD      = 32;
   localparam int CURSOR_MAX     = (1 << CURSOR_W) - 1;
   localparam int SCREEN_W       = DEFAULT_SCREEN_WIDTH;
   localparam int SCREEN_H       = DEFAULT_SCREEN_HEIGHT;
   localparam int DIR_ROWS       = 25;

   // One character request as offered on the input channel.
   typedef struct packed {
      logic [7:0]          char_code;
      logic                first_of_string;
      logic [CURSOR_W-1:0] start_x;
      logic [CURSOR_W-1:0] start_y;
      logic [15:0]         fg_color;
      logic [15:0]         bg_color;
      logic [SCALE_W-1:0]  pixel_scale;
   } char_req_type;

   // One cell rectangle as seen on the result channel.
   typedef struct packed {
      logic [OUT_W-1:0] x_start;
      logic [OUT_W-1:0] y_start;
      logic [OUT_W-1:0] x_end;
      logic [OUT_W-1:0] y_end;
      logic [15:0]      color;
      logic             visible;
      logic             last_cell;
   } rect_cell_type;

   // Directed row: a request and, where it is obvious, the typed first cell.
   typedef struct packed {
      logic [7:0]          char_code;
      logic                first_of_string;
      logic [CURSOR_W-1:0] start_x;
      logic [CURSOR_W-1:0] start_y;
      logic [15:0]         fg_color;
      logic [15:0]         bg_color;
      logic [SCALE_W-1:0]  pixel_scale;
      logic                typed;
      logic [OUT_W-1:0]    x_start;
      logic [OUT_W-1:0]    y_start;
      logic [OUT_W-1:0]    x_end;
      logic [OUT_W-1:0]    y_end;
      logic [15:0]         color;
      logic                visible;
   } dir_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [7:0]          req_char_code = '0;
   logic                req_first_of_string = 1'b0;
   logic [CURSOR_W-1:0] req_start_x = '0;
   logic [CURSOR_W-1:0] req_start_y = '0;
   logic [15:0]         req_fg_color = '0;
   logic [15:0]         req_bg_color = '0;
   logic [SCALE_W-1:0]  req_pixel_scale = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [OUT_W-1:0]    rsp_rect_x_start;
   logic [OUT_W-1:0]    rsp_rect_y_start;
   logic [OUT_W-1:0]    rsp_rect_x_end;
   logic [OUT_W-1:0]    rsp_rect_y_end;
   logic [15:0]         rsp_rect_color;
   logic                rsp_visible;
   logic                rsp_last_cell;

   // Predicted cursor and string row, and the cells still to be drawn.
   logic [CURSOR_W-1:0] pen_x = '0;
   logic [CURSOR_W-1:0] pen_y = '0;
   rect_cell_type       expected_rects[$];

   int send_idle_pct  = 14;
   int recv_stall_pct = 75;
   int mismatches     = 0;
   int rects_seen     = 0;
   int quiet_cycles   = 0;
   int hold_cnt       = 0;
   logic hold_req     = 1'b0;
   logic hold_taken   = 1'b0;

   // Directed rows: reset state, extremes, case folding, blanks, clipping, zero and wide scale.
   dir_row_type directed_rows [DIR_ROWS] = '{
      '{" ",   1'b0, 12'hFFF, 12'hFFF, 16'hFFFF, 16'h0000, 4'd1,
        1'b1, 8'd0,   8'd0,   8'd1,   8'd1,   16'h0000, 1'b1},
      '{"A",   1'b1, 12'd0,   12'd0,   16'hF800, 16'h001F, 4'd8,
        1'b1, 8'd0,   8'd0,   8'd8,   8'd8,   16'h001F, 1'b1},
      '{"a",   1'b0, 12'd0,   12'd0,   16'h07E0, 16'hF81F, 4'd8,
        1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'h0000, 1'b0},
      '{"Z",   1'b0, 12'd0,   12'd0,   16'h07E0, 16'hF81F, 4'd8,
        1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'h0000, 1'b0},
      '{"z",   1'b0, 12'd0,   12'd0,   16'h1111, 16'hEEEE, 4'd8,
        1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'h0000, 1'b0},
      '{"E",   1'b0, 12'd0,   12'd0,   16'h2222, 16'hDDDD, 4'd8,
        1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'h0000, 1'b0},
      '{"E",   1'b0, 12'd0,   12'd0,   16'h7BEF, 16'h0000, 4'd8,
        1'b1, 8'd0,   8'd0,   8'd0,   8'd0,   16'h7BEF, 1'b0},
      '{"E",   1'b1, 12'd232, 12'd232, 16'hFFE0, 16'h0841, 4'd8,
        1'b1, 8'd232, 8'd232, 8'd240, 8'd240, 16'hFFE0, 1'b1},
      '{"M",   1'b1, 12'hFFF, 12'hFFF, 16'hAAAA, 16'h5555, 4'd15,
        1'b1, 8'd0,   8'd0,   8'd0,   8'd0,   16'hAAAA, 1'b0},
      '{"J",   1'b0, 12'd0,   12'd0,   16'hFFFF, 16'h0000, 4'd15,
        1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'h0000, 1'b0},
      '{"Q",   1'b1, 12'd10,  12'd20,  16'h1234, 16'hABCD, 4'd3,
        1'b1, 8'd10,  8'd20,  8'd13,  8'd23,  16'hABCD, 1'b1},
      '{8'hFF, 1'b0, 12'd0,   12'd0,   16'hFFFF, 16'h8001, 4'd15,
        1'b1, 8'd28,  8'd20,  8'd43,  8'd35,  16'h8001, 1'b1},
      '{8'h80, 1'b0, 12'd0,   12'd0,   16'h0F0F, 16'hF0F0, 4'd9,
        1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'h0000, 1'b0},
      '{8'h00, 1'b1, 12'd100, 12'd100, 16'hFFFF, 16'h4210, 4'd0,
        1'b1, 8'd0,   8'd0,   8'd0,   8'd0,   16'h4210, 1'b0},
      '{"0",   1'b0, 12'd0,   12'd0,   16'h3333, 16'hCCCC, 4'd0,
        1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'h0000, 1'b0},
      '{"%",   1'b0, 12'd0,   12'd0,   16'h4444, 16'hBBBB, 4'd2,
        1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'h0000, 1'b0},
      '{8'h60, 1'b0, 12'd0,   12'd0,   16'h5555, 16'hAAAA, 4'd4,
        1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'h0000, 1'b0},
      '{8'h7B, 1'b0, 12'd0,   12'd0,   16'h6666, 16'h9999, 4'd5,
        1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'h0000, 1'b0},
      '{8'h5B, 1'b0, 12'd0,   12'd0,   16'h7777, 16'h8888, 4'd1,
        1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'h0000, 1'b0},
      '{"8",   1'b1, 12'd4000, 12'd0,  16'hFFFF, 16'h0001, 4'd15,
        1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'h0000, 1'b0},
      '{"9",   1'b0, 12'd0,   12'd0,   16'hFFFF, 16'h0001, 4'd15,
        1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'h0000, 1'b0},
      '{":",   1'b0, 12'd0,   12'd0,   16'hFFFF, 16'h0001, 4'd1,
        1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'h0000, 1'b0},
      '{".",   1'b1, 12'd0,   12'd233, 16'hC618, 16'h39E7, 4'd1,
        1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'h0000, 1'b0},
      '{"-",   1'b1, 12'd0,   12'd234, 16'hC618, 16'h39E7, 4'd1,
        1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'h0000, 1'b0},
      '{"W",   1'b1, 12'd0,   12'd0,   16'hFFFF, 16'hFFFF, 4'd1,
        1'b0, 8'd0,   8'd0,   8'd0,   8'd0,   16'h0000, 1'b0}
   };

   scaled_font_cell_renderer u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_char_code       (req_char_code),
      .req_first_of_string (req_first_of_string),
      .req_start_x         (req_start_x),
      .req_start_y         (req_start_y),
      .req_fg_color        (req_fg_color),
      .req_bg_color        (req_bg_color),
      .req_pixel_scale     (req_pixel_scale),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_rect_x_start    (rsp_rect_x_start),
      .rsp_rect_y_start    (rsp_rect_y_start),
      .rsp_rect_x_end      (rsp_rect_x_end),
      .rsp_rect_y_end      (rsp_rect_y_end),
      .rsp_rect_color      (rsp_rect_color),
      .rsp_visible         (rsp_visible),
      .rsp_last_cell       (rsp_last_cell)
   );

   // Free-running clock.
   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // Font glyph of a code, top row in the high bits, leftmost column in bit 4 of each row.
   function automatic logic [GLYPH_CELLS-1:0] font_glyph(input logic [7:0] code);
      logic [7:0] ch;
      ch = code;
      if (ch >= "a" && ch <= "z") begin
         ch = ch - 8'(CASE_FOLD);
      end
      case (ch)
         "%": font_glyph = {5'h19, 5'h1A, 5'h02, 5'h04, 5'h08, 5'h0B, 5'h13};
         "-": font_glyph = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
         ".": font_glyph = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h06, 5'h06};
         "0": font_glyph = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
         "1": font_glyph = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
         "2": font_glyph = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
         "3": font_glyph = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
         "4": font_glyph = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
         "5": font_glyph = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
         "6": font_glyph = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
         "7": font_glyph = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
         "8": font_glyph = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
         "9": font_glyph = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
         ":": font_glyph = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
         "A": font_glyph = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
         "B": font_glyph = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
         "C": font_glyph = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
         "D": font_glyph = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
         "E": font_glyph = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
         "F": font_glyph = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
         "G": font_glyph = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0E};
         "H": font_glyph = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
         "I": font_glyph = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
         "K": font_glyph = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
         "L": font_glyph = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
         "M": font_glyph = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
         "N": font_glyph = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
         "O": font_glyph = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
         "P": font_glyph = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
         "R": font_glyph = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
         "S": font_glyph = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
         "T": font_glyph = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
         "U": font_glyph = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
         "V": font_glyph = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
         "W": font_glyph = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
         "X": font_glyph = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
         "Y": font_glyph = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
         "Z": font_glyph = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
         default: font_glyph = '0;
      endcase
   endfunction

   // Renders one character into the expected cell list and advances the predicted cursor.
   task automatic render_char(input char_req_type r);
      logic [GLYPH_CELLS-1:0] glyph;
      rect_cell_type          rc;
      int                     x1, y1, x2, y2, row, col, nx;
      logic                   lit;
      if (r.first_of_string) begin
         pen_x = r.start_x;
         pen_y = r.start_y;
      end
      glyph = font_glyph(r.char_code);
      for (row = 0; row < GLYPH_ROWS; row++) begin
         for (col = 0; col < GLYPH_COLS; col++) begin
            x1  = pen_x + col * r.pixel_scale;
            y1  = pen_y + row * r.pixel_scale;
            x2  = x1 + r.pixel_scale;
            y2  = y1 + r.pixel_scale;
            x2  = (x2 > SCREEN_W) ? SCREEN_W : x2;
            y2  = (y2 > SCREEN_H) ? SCREEN_H : y2;
            lit = glyph[GLYPH_CELLS - 1 - (row * GLYPH_COLS + col)];
            rc.visible   = (x2 > x1) && (y2 > y1);
            rc.x_start   = rc.visible ? x1[OUT_W-1:0] : '0;
            rc.y_start   = rc.visible ? y1[OUT_W-1:0] : '0;
            rc.x_end     = rc.visible ? x2[OUT_W-1:0] : '0;
            rc.y_end     = rc.visible ? y2[OUT_W-1:0] : '0;
            rc.color     = lit ? r.fg_color : r.bg_color;
            rc.last_cell = (row == GLYPH_ROWS - 1) && (col == GLYPH_COLS - 1);
            expected_rects.push_back(rc);
         end
      end
      nx    = pen_x + ADVANCE_CELLS * r.pixel_scale;
      pen_x = CURSOR_W'((nx > CURSOR_MAX) ? CURSOR_MAX : nx);
   endtask

   // Offers one character, after random idle cycles, and predicts it once the transfer happens.
   task automatic offer_char(input char_req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_char_code       <= r.char_code;
      req_first_of_string <= r.first_of_string;
      req_start_x         <= r.start_x;
      req_start_y         <= r.start_y;
      req_fg_color        <= r.fg_color;
      req_bg_color        <= r.bg_color;
      req_pixel_scale     <= r.pixel_scale;
      do @(posedge clock); while (req_stall);
      render_char(r);
   endtask

   function automatic string rect_text(input rect_cell_type c);
      return $sformatf("x %0d..%0d y %0d..%0d color %h visible %b last %b",
                       c.x_start, c.x_end, c.y_start, c.y_end, c.color, c.visible,
                       c.last_cell);
   endfunction

   // Receiver stall: random, with one long hold-off counted here.
   always @(posedge clock) begin
      if (hold_req && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_cnt   <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else if (hold_cnt != 0) begin
         hold_cnt  <= hold_cnt - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
      end
   end

   // Compare each result transfer with the oldest expected cell.
   always @(posedge clock) begin : check_rects
      rect_cell_type seen;
      rect_cell_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen = {rsp_rect_x_start, rsp_rect_y_start, rsp_rect_x_end, rsp_rect_y_end,
                 rsp_rect_color, rsp_visible, rsp_last_cell};
         if (expected_rects.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected cell rectangle %0d: %s", rects_seen, rect_text(seen));
            end
         end else begin
            want = expected_rects.pop_front();
            if (seen !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("cell rectangle %0d mismatch", rects_seen);
                  $display("   expected %s", rect_text(want));
                  $display("   actual   %s", rect_text(seen));
               end
            end
         end
         rects_seen++;
      end
   end

   // Watchdog: too long without any transfer on either channel ends the run.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("scaled_font_cell_renderer_tb NOT OK");
         $finish;
      end
   end

   // Stimulus: reset, directed rows, then three phases of random strings with varied idle and stall rates.
   initial begin : stimulus
      char_req_type r;
      int           i, phase, pick;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < DIR_ROWS; i++) begin
         r = {directed_rows[i].char_code, directed_rows[i].first_of_string,
              directed_rows[i].start_x, directed_rows[i].start_y,
              directed_rows[i].fg_color, directed_rows[i].bg_color,
              directed_rows[i].pixel_scale};
         offer_char(r);
         // Typed first cell replaces the predicted one for the obvious rows.
         if (directed_rows[i].typed) begin
            expected_rects[expected_rects.size() - GLYPH_CELLS] =
               {directed_rows[i].x_start, directed_rows[i].y_start,
                directed_rows[i].x_end, directed_rows[i].y_end,
                directed_rows[i].color, directed_rows[i].visible, 1'b0};
         end
      end

      for (phase = 0; phase < PHASES; phase++) begin
         send_idle_pct  = (phase == 0) ? 14 : (phase == 1) ? 75 : 0;
         recv_stall_pct = (phase == 0) ? 75 : (phase == 1) ? 14 : 0;
         // Long receiver hold-off while the sender keeps offering.
         if (phase == PHASES - 1) begin
            hold_req <= 1'b1;
         end
         for (i = 0; i < RANDOM_ITEMS / PHASES + 1; i++) begin
            r.first_of_string = ($urandom_range(0, 5) == 0);
            r.start_x = CURSOR_W'(($urandom_range(0, 9) < 7) ?
                                  $urandom_range(0, SCREEN_W - 1) :
                                  $urandom_range(0, CURSOR_MAX));
            r.start_y = CURSOR_W'(($urandom_range(0, 9) < 7) ?
                                  $urandom_range(0, SCREEN_H - 1) :
                                  $urandom_range(0, CURSOR_MAX));
            pick = $urandom_range(0, 9);
            r.pixel_scale = SCALE_W'((pick == 0) ? 0 :
                                     (pick == 1) ? $urandom_range(9, 15) :
                                                   $urandom_range(1, 8));
            pick = $urandom_range(0, 3);
            r.char_code = 8'((pick < 2) ? $urandom_range(" ", "Z") :
                             (pick == 2) ? $urandom_range("a", "z") :
                                           $urandom_range(0, 255));
            r.fg_color = 16'($urandom);
            r.bg_color = 16'($urandom);
            offer_char(r);
         end
      end
      req_valid <= 1'b0;

      // Drain the outstanding cells, then leave room for stray results.
      while (expected_rects.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("scaled_font_cell_renderer_tb OK");
      end else begin
         $display("scaled_font_cell_renderer_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/sfcr_pkg.sv
rtl/sfcr_font_rom.sv
rtl/sfcr_clip.sv
rtl/scaled_font_cell_renderer.sv
tb/sv/scaled_font_cell_renderer_tb.sv
